>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the text cell decoder.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock with an active-low reset that disables it.
`define TCAD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the standard clk_i / rst_ni pair.
`define TCAD_ASSERT_IO(name, prop, msg) \
  `TCAD_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/tcad_pkg.sv
// Shared types and constants of the text cell attribute decoder.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package tcad_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned VisibleLinesDefault = 240;
  localparam int unsigned QueueDepthDefault   = 2;

  // Field widths fixed by the cell format
  localparam int unsigned LineW   = 9;
  localparam int unsigned ColumnW = 7;

  // Attribute values after a row start, and the raster row at the cursor column
  localparam logic [2:0] FgReset   = 3'd7;
  localparam logic [2:0] BgReset   = 3'd0;
  localparam logic [3:0] CursorRow = 4'hf;

  // Serial control codes in attribute bits 7:6
  localparam logic [1:0] CtrlBlank = 2'b10;
  localparam logic [1:0] CtrlWide  = 2'b11;

  // One input text cell
  typedef struct packed {
    logic                 row_start;
    logic [7:0]           char_code;
    logic [7:0]           attr_byte;
    logic [7:0]           next_attr_byte;
    logic [3:0]           raster_row;
    logic [ColumnW-1:0]   cursor_column;
    logic [LineW-1:0]     scan_line;
  } cell_t;

  // One result word for a shown cell
  typedef struct packed {
    logic [11:0]          glyph_address;
    logic [2:0]           ink_color;
    logic [2:0]           paper_color;
    logic                 double_width;
    logic                 underline_on;
    logic                 flash_on;
    logic [ColumnW-1:0]   cell_column;
  } glyph_t;

  // Attribute action decided by the front end
  typedef enum logic [1:0] {
    ATTR_KEEP,
    ATTR_LOAD,
    ATTR_BLANK,
    ATTR_WIDE
  } attr_op_e;

  // Classified cell held in the queue
  typedef struct packed {
    logic                 row_start;
    logic [7:0]           char_code;
    attr_op_e             op;
    logic [7:0]           attr_src;
    logic                 load_next;
    logic [1:0]           wide_bits;
    logic [3:0]           raster_row;
    logic [ColumnW-1:0]   cursor_column;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcad_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Depends on nothing; the payload type is set per instance.
`default_nettype none

interface tcad_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tcad_front.sv
// Front end: accepts text cells, drops invisible lines and classifies attributes.
// Depends on tcad_pkg and tcad_stream_if.
`default_nettype none

module tcad_front #(
  parameter int unsigned VISIBLE_LINES = tcad_pkg::VisibleLinesDefault
) (
  tcad_stream_if.sink       cell_i,
  input  logic              full_i,
  output logic              push_o,
  output tcad_pkg::entry_t  entry_o
);

  localparam logic [tcad_pkg::LineW-1:0] VisLimit = tcad_pkg::LineW'(VISIBLE_LINES);

  logic       visible;
  logic       ctrl_attr;
  logic [7:0] attr;

  assign attr      = cell_i.data.attr_byte;
  assign visible   = cell_i.data.scan_line < VisLimit;
  assign ctrl_attr = attr[2:0] == attr[5:3];

  // Take a word whenever the queue has room; invisible words are dropped here
  assign cell_i.ready = !full_i;
  assign push_o       = cell_i.valid && !full_i && visible;

  // Classify the attribute byte
  always_comb begin
    entry_o.row_start     = cell_i.data.row_start;
    entry_o.char_code     = cell_i.data.char_code;
    entry_o.raster_row    = cell_i.data.raster_row;
    entry_o.cursor_column = cell_i.data.cursor_column;
    entry_o.wide_bits     = attr[1:0];
    entry_o.load_next     = cell_i.data.next_attr_byte != 8'd0;
    entry_o.attr_src      = attr;
    entry_o.op            = tcad_pkg::ATTR_LOAD;
    if (ctrl_attr) begin
      case (attr[7:6])
        tcad_pkg::CtrlBlank: entry_o.op = tcad_pkg::ATTR_BLANK;
        tcad_pkg::CtrlWide: begin
          entry_o.op       = tcad_pkg::ATTR_WIDE;
          entry_o.attr_src = cell_i.data.next_attr_byte;
        end
        default: entry_o.op = tcad_pkg::ATTR_KEEP;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcad_queue.sv
// Short first-in first-out queue of classified cells between front and back end.
// Depends on tcad_pkg.
`default_nettype none

module tcad_queue #(
  parameter int unsigned DEPTH = tcad_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcad_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tcad_pkg::entry_t  entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tcad_pkg::entry_t slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == FullCnt;
  assign empty_o = count_q == '0;
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcad_back.sv
// Back end: applies attributes, tracks column and skip, registers the result word.
// Holds the forty-column register. Depends on tcad_pkg and tcad_stream_if.
`default_nettype none

module tcad_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcad_stream_if.sink       cfg_i,
  input  tcad_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  tcad_stream_if.source     glyph_o
);

  localparam int unsigned ColW = tcad_pkg::ColumnW;

  logic            forty_q;
  logic [2:0]      fg_q, fg_d, bg_q, bg_d;
  logic            ul_q, ul_d, fl_q, fl_d;
  logic            wide_lo_q, wide_lo_d, wide_hi_q, wide_hi_d;
  logic [ColW-1:0] col_q, col_d;
  logic            skip_q, skip_d;
  logic            out_valid_q, out_valid_d;
  tcad_pkg::glyph_t out_q, out_d;

  logic            skip_cell, out_free, load_out;
  logic [ColW-1:0] base_col;
  logic [3:0]      row;

  // Configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forty_q <= 1'b1;
    end else if (cfg_i.valid) begin
      forty_q <= cfg_i.data;
    end
  end

  assign skip_cell = !entry_i.row_start && skip_q;
  assign out_free  = !out_valid_q || glyph_o.ready;
  assign pop_o     = !empty_i && (skip_cell || out_free);
  assign load_out  = pop_o && !skip_cell;
  assign base_col  = entry_i.row_start ? '0 : col_q;
  assign row       = (base_col == entry_i.cursor_column) ? tcad_pkg::CursorRow
                                                          : entry_i.raster_row;

  // Decode one cell against the running attributes
  always_comb begin
    fg_d        = fg_q;
    bg_d        = bg_q;
    ul_d        = ul_q;
    fl_d        = fl_q;
    wide_lo_d   = wide_lo_q;
    wide_hi_d   = wide_hi_q;
    col_d       = col_q;
    skip_d      = skip_q;
    out_valid_d = out_valid_q && !glyph_o.ready;
    out_d       = out_q;

    if (pop_o && skip_cell) begin
      skip_d = 1'b0;
      col_d  = col_q + 1'b1;
    end else if (load_out) begin
      // restart the row
      if (entry_i.row_start) begin
        fg_d      = tcad_pkg::FgReset;
        bg_d      = tcad_pkg::BgReset;
        ul_d      = 1'b0;
        fl_d      = 1'b0;
        wide_lo_d = forty_q;
        wide_hi_d = forty_q;
      end
      case (entry_i.op)
        tcad_pkg::ATTR_LOAD: begin
          {fl_d, ul_d, bg_d, fg_d} = entry_i.attr_src;
          wide_lo_d = forty_q;
          wide_hi_d = forty_q;
        end
        tcad_pkg::ATTR_BLANK: begin
          fg_d = 3'd0;
          bg_d = 3'd0;
          ul_d = 1'b0;
          fl_d = 1'b0;
        end
        tcad_pkg::ATTR_WIDE: begin
          wide_lo_d = entry_i.wide_bits[0];
          wide_hi_d = entry_i.wide_bits[1];
          if (entry_i.load_next) begin
            {fl_d, ul_d, bg_d, fg_d} = entry_i.attr_src;
          end
        end
        default: ;
      endcase

      out_d.glyph_address = {entry_i.char_code, row};
      out_d.ink_color     = fg_d;
      out_d.paper_color   = bg_d;
      out_d.double_width  = wide_lo_d | wide_hi_d;
      out_d.underline_on  = ul_d;
      out_d.flash_on      = fl_d;
      out_d.cell_column   = base_col;
      out_valid_d         = 1'b1;
      skip_d              = wide_lo_d | wide_hi_d;
      col_d               = base_col + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q        <= tcad_pkg::FgReset;
      bg_q        <= tcad_pkg::BgReset;
      ul_q        <= 1'b0;
      fl_q        <= 1'b0;
      wide_lo_q   <= 1'b1;
      wide_hi_q   <= 1'b1;
      col_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      ul_q        <= ul_d;
      fl_q        <= fl_d;
      wide_lo_q   <= wide_lo_d;
      wide_hi_q   <= wide_hi_d;
      col_q       <= col_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign glyph_o.valid = out_valid_q;
  assign glyph_o.data  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/text_cell_attribute_decoder.sv
// Top level of the text cell attribute decoder: front end, queue, back end.
// Depends on tcad_pkg, tcad_stream_if, tcad_front, tcad_queue, tcad_back.
//
//   channel   dir   payload             word moved
//   cell_i    in    tcad_pkg::cell_t    one text cell
//   cfg_i     in    logic               forty_column_mode
//   glyph_o   out   tcad_pkg::glyph_t   one shown cell
//
// One cell per clock while the queue has room; a shown cell goes into a queue slot
// when taken, and into the output register at the head once the register is free.
// Lines at or past VISIBLE_LINES and cells skipped after a wide cell give no word.
// cell_i stalls only when the QUEUE_DEPTH-entry queue is full behind a held output.
// Reset is asynchronous, active low; no clearing pass is needed.
`default_nettype none

module text_cell_attribute_decoder #(
  parameter int unsigned VISIBLE_LINES = tcad_pkg::VisibleLinesDefault,
  parameter int unsigned QUEUE_DEPTH   = tcad_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcad_stream_if.sink   cell_i,
  tcad_stream_if.sink   cfg_i,
  tcad_stream_if.source glyph_o
);

  logic             push, full, pop, empty;
  tcad_pkg::entry_t push_entry, head_entry;

  tcad_front #(
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_front (
    .cell_i  (cell_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  tcad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  tcad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .glyph_o (glyph_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tcad_checker.sv
// Port-level checker for the text cell attribute decoder, bound to the top level.
// Depends on tcad_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcad_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input tcad_pkg::glyph_t out_data_i
);

  logic [3:0] pend_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Count words taken but not yet answered; stick once saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pend_q != '1) begin
      if (in_fire && !out_fire) begin
        pend_q <= pend_q + 1'b1;
      end else if (out_fire && !in_fire && pend_q != '0) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  `TCAD_ASSERT_IO(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result word changed while stalled")
  `TCAD_ASSERT_IO(a_out_has_cell, out_fire |-> pend_q != '0, "result word without a taken cell")
  `TCAD_ASSERT_IO(a_in_stall_cause, !in_ready_i |-> $past(out_valid_i && !out_ready_i), "input stalled without a held result")

endmodule

bind text_cell_attribute_decoder tcad_checker u_tcad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_i.valid),
  .in_ready_i  (cell_i.ready),
  .out_valid_i (glyph_o.valid),
  .out_ready_i (glyph_o.ready),
  .out_data_i  (glyph_o.data)
);

`default_nettype wire

>>> dv/text_cell_attribute_decoder_checker.sv
// Checker for the text cell attribute decoder: watches the cell, mode and glyph channels.
// Depends on tcad_pkg; predicts each shown cell and compares it with the glyph words.
`timescale 1ns / 100ps

module text_cell_attribute_decoder_checker #(
  parameter int unsigned VISIBLE_LINES = tcad_pkg::VisibleLinesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cell_valid_i,
  input  logic             cell_ready_i,
  input  tcad_pkg::cell_t  cell_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_data_i,
  input  logic             glyph_valid_i,
  input  logic             glyph_ready_i,
  input  tcad_pkg::glyph_t glyph_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  // Running attribute state of the predicted decoder
  logic       forty_q;
  logic [2:0] fg_q;
  logic [2:0] bg_q;
  logic       ul_q;
  logic       fl_q;
  logic       wide_lo_q;
  logic       wide_hi_q;
  logic [6:0] col_q;
  logic       skip_q;

  tcad_pkg::glyph_t expected_glyphs[$];
  int unsigned      fails = 0;
  int unsigned      pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: glyph %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fails++;
  endtask

  function automatic void load_attr(input logic [7:0] a);
    fg_q = a[2:0];
    bg_q = a[5:3];
    ul_q = a[6];
    fl_q = a[7];
  endfunction

  // Advance the attribute state by one cell; return 1 and the glyph word if it is shown
  function automatic bit decode_cell(input tcad_pkg::cell_t c, output tcad_pkg::glyph_t g);
    logic [3:0] row;
    logic       wide;
    g = '0;
    // Invisible lines leave everything alone, row start included
    if (c.scan_line >= VISIBLE_LINES) return 1'b0;
    if (c.row_start) begin
      fg_q      = tcad_pkg::FgReset;
      bg_q      = tcad_pkg::BgReset;
      ul_q      = 1'b0;
      fl_q      = 1'b0;
      wide_lo_q = forty_q;
      wide_hi_q = forty_q;
      col_q     = '0;
      skip_q    = 1'b0;
    end else if (skip_q) begin
      // Drop the cell covered by the previous wide cell
      skip_q = 1'b0;
      col_q  = col_q + 7'd1;
      return 1'b0;
    end
    if (c.attr_byte[2:0] == c.attr_byte[5:3]) begin
      // Serial control: equal colour fields
      case (c.attr_byte[7:6])
        tcad_pkg::CtrlBlank: begin
          fg_q = '0;
          bg_q = '0;
          ul_q = 1'b0;
          fl_q = 1'b0;
        end
        tcad_pkg::CtrlWide: begin
          wide_lo_q = c.attr_byte[0];
          wide_hi_q = c.attr_byte[1];
          if (c.next_attr_byte != 8'h00) load_attr(c.next_attr_byte);
        end
        default: ;
      endcase
    end else begin
      load_attr(c.attr_byte);
      wide_lo_q = forty_q;
      wide_hi_q = forty_q;
    end
    row  = (col_q == c.cursor_column) ? tcad_pkg::CursorRow : c.raster_row;
    wide = wide_lo_q | wide_hi_q;
    g.glyph_address = {c.char_code, row};
    g.ink_color     = fg_q;
    g.paper_color   = bg_q;
    g.double_width  = wide;
    g.underline_on  = ul_q;
    g.flash_on      = fl_q;
    g.cell_column   = col_q;
    skip_q = wide;
    col_q  = col_q + 7'd1;
    return 1'b1;
  endfunction

  // Compare words first, then take mode writes and new cells of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    tcad_pkg::glyph_t want;
    tcad_pkg::glyph_t pred;
    if (!rst_ni) begin
      forty_q   = 1'b1;
      fg_q      = tcad_pkg::FgReset;
      bg_q      = tcad_pkg::BgReset;
      ul_q      = 1'b0;
      fl_q      = 1'b0;
      wide_lo_q = 1'b1;
      wide_hi_q = 1'b1;
      col_q     = '0;
      skip_q    = 1'b0;
      expected_glyphs.delete();
    end else begin
      if (glyph_valid_i && glyph_ready_i) begin
        if (expected_glyphs.size() == 0) begin
          report_mismatch("word with none expected", int'(glyph_data_i.glyph_address), 0);
        end else begin
          want = expected_glyphs.pop_front();
          if (glyph_data_i.glyph_address != want.glyph_address)
            report_mismatch("glyph_address", int'(glyph_data_i.glyph_address),
                            int'(want.glyph_address));
          if (glyph_data_i.ink_color != want.ink_color)
            report_mismatch("ink_color", int'(glyph_data_i.ink_color), int'(want.ink_color));
          if (glyph_data_i.paper_color != want.paper_color)
            report_mismatch("paper_color", int'(glyph_data_i.paper_color),
                            int'(want.paper_color));
          if (glyph_data_i.double_width != want.double_width)
            report_mismatch("double_width", int'(glyph_data_i.double_width),
                            int'(want.double_width));
          if (glyph_data_i.underline_on != want.underline_on)
            report_mismatch("underline_on", int'(glyph_data_i.underline_on),
                            int'(want.underline_on));
          if (glyph_data_i.flash_on != want.flash_on)
            report_mismatch("flash_on", int'(glyph_data_i.flash_on), int'(want.flash_on));
          if (glyph_data_i.cell_column != want.cell_column)
            report_mismatch("cell_column", int'(glyph_data_i.cell_column),
                            int'(want.cell_column));
        end
      end
      if (cfg_valid_i && cfg_ready_i) forty_q = cfg_data_i;
      if (cell_valid_i && cell_ready_i) begin
        if (decode_cell(cell_data_i, pred)) expected_glyphs.push_back(pred);
      end
    end
    pending = expected_glyphs.size();
  end

endmodule

>>> dv/text_cell_attribute_decoder_tb.sv
// Top of the text cell attribute decoder testbench: clock, reset, cell and mode stimulus.
// Depends on tcad_pkg, tcad_stream_if, the decoder and text_cell_attribute_decoder_checker.
`timescale 1ns / 100ps

module text_cell_attribute_decoder_tb;

  localparam int unsigned VisibleLines = tcad_pkg::VisibleLinesDefault;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseCells   = 170;

  logic clk_i;
  logic rst_ni;

  tcad_stream_if #(.payload_t(tcad_pkg::cell_t))  cell_if ();
  tcad_stream_if #(.payload_t(logic))             cfg_if ();
  tcad_stream_if #(.payload_t(tcad_pkg::glyph_t)) glyph_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;

  text_cell_attribute_decoder #(
    .VISIBLE_LINES(VisibleLines)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_if),
    .cfg_i  (cfg_if),
    .glyph_o(glyph_if)
  );

  text_cell_attribute_decoder_checker #(
    .VISIBLE_LINES(VisibleLines)
  ) glyph_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_if.valid),
    .cell_ready_i (cell_if.ready),
    .cell_data_i  (cell_if.data),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_data_i   (cfg_if.data),
    .glyph_valid_i(glyph_if.valid),
    .glyph_ready_i(glyph_if.ready),
    .glyph_data_i (glyph_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cell_if.valid && cell_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (glyph_if.valid && glyph_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("text_cell_attribute_decoder_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Glyph sink: random stall before each word, with stall-free stretches
  initial begin
    int unsigned stall;
    int unsigned burst;
    burst = 0;
    glyph_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (burst > 0) begin
        stall = 0;
        burst--;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
      end
      repeat (stall) begin
        @(negedge clk_i);
        glyph_if.ready = 1'b0;
      end
      @(negedge clk_i);
      glyph_if.ready = 1'b1;
      do @(posedge clk_i); while (!glyph_if.valid);
    end
  end

  function automatic tcad_pkg::cell_t cell_of(input logic rs, input logic [7:0] ch,
                                              input logic [7:0] attr, input logic [7:0] nxt,
                                              input logic [3:0] ras, input logic [6:0] cur,
                                              input logic [8:0] line);
    tcad_pkg::cell_t c;
    c.row_start      = rs;
    c.char_code      = ch;
    c.attr_byte      = attr;
    c.next_attr_byte = nxt;
    c.raster_row     = ras;
    c.cursor_column  = cur;
    c.scan_line      = line;
    return c;
  endfunction

  // Random cell: half colour pairs, half serial controls, some invisible lines
  function automatic tcad_pkg::cell_t random_cell(input bit first);
    tcad_pkg::cell_t c;
    logic [2:0]      f;
    c.row_start = first ? 1'b1 : ($urandom_range(0, 49) == 0);
    c.char_code = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      c.attr_byte = 8'($urandom_range(0, 255));
    end else begin
      f = 3'($urandom_range(0, 7));
      c.attr_byte = {2'($urandom_range(0, 3)), f, f};
    end
    c.next_attr_byte = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    c.raster_row     = 4'($urandom_range(0, 15));
    c.cursor_column  = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 20))
                                                   : 7'($urandom_range(0, 127));
    c.scan_line      = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(VisibleLines, 511))
                                                   : 9'($urandom_range(0, VisibleLines - 1));
    return c;
  endfunction

  // Present one cell after a random gap (none when no_gaps is set) and hold it until taken
  task automatic put_cell(input tcad_pkg::cell_t c);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      cell_if.valid = 1'b0;
    end
    @(negedge clk_i);
    cell_if.valid = 1'b1;
    cell_if.data  = c;
    do @(posedge clk_i); while (!cell_if.ready);
  endtask

  // Hold off cells until every expected word is out and the pipe has drained
  task automatic drain;
    @(negedge clk_i);
    cell_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write the forty-column mode while the block is idle
  task automatic write_mode(input logic mode);
    drain();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    tcad_pkg::cell_t c;
    int unsigned     shown;
    int unsigned     len;
    logic            mode;
    rst_ni         = 1'b0;
    cell_if.valid  = 1'b0;
    cell_if.data   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Forty-column default: wide cells and the skipped cell after them
    put_cell(cell_of(1'b1, 8'h41, 8'h3a, 8'h00, 4'h3, 7'd0, 9'd0));
    put_cell(cell_of(1'b0, 8'h42, 8'h3a, 8'h00, 4'h3, 7'd5, 9'd0));
    put_cell(cell_of(1'b0, 8'h43, 8'h00, 8'h00, 4'h3, 7'd2, 9'd0));

    // Eighty columns: keep, blank, reserved and every wide control
    write_mode(1'b0);
    put_cell(cell_of(1'b1, 8'hff, 8'h00, 8'hff, 4'hf, 7'h7f, 9'd239));
    put_cell(cell_of(1'b0, 8'h00, 8'h07, 8'h00, 4'h0, 7'd1, 9'd0));
    put_cell(cell_of(1'b0, 8'h80, 8'h92, 8'h00, 4'h5, 7'h7f, 9'd100));
    put_cell(cell_of(1'b0, 8'h10, 8'h49, 8'h00, 4'ha, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h20, 8'hc0, 8'h00, 4'h1, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h21, 8'hd2, 8'ha5, 4'h2, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h5a, 8'h3a, 8'h00, 4'h2, 7'd6, 9'd100));
    put_cell(cell_of(1'b0, 8'h22, 8'hc9, 8'h00, 4'h2, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h5b, 8'h3a, 8'h00, 4'h2, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h23, 8'hff, 8'hff, 4'h4, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h5c, 8'h3a, 8'h00, 4'h4, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h24, 8'h3a, 8'h00, 4'h4, 7'd0, 9'd100));
    put_cell(cell_of(1'b0, 8'h25, 8'h12, 8'h00, 4'h4, 7'd0, 9'd100));
    // Invisible lines, row start included, change nothing
    put_cell(cell_of(1'b1, 8'h77, 8'h3a, 8'h00, 4'h4, 7'd0, 9'd240));
    put_cell(cell_of(1'b1, 8'h78, 8'h92, 8'h00, 4'h4, 7'd0, 9'd511));
    put_cell(cell_of(1'b0, 8'h26, 8'h05, 8'h00, 4'h4, 7'd14, 9'd0));

    // Back to forty columns; a wide control can still turn width off
    write_mode(1'b1);
    put_cell(cell_of(1'b1, 8'h30, 8'hc0, 8'h00, 4'h7, 7'd9, 9'd1));
    put_cell(cell_of(1'b0, 8'h31, 8'h1d, 8'h00, 4'h7, 7'd1, 9'd1));

    // Random rows under several mode settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0, 2:    mode = 1'b0;
        1, 3:    mode = 1'b1;
        default: mode = 1'($urandom_range(0, 1));
      endcase
      write_mode(mode);
      shown = 0;
      while (shown < PhaseCells) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 40);
        for (int i = 0; i <= len; i++) begin
          c = random_cell(i == 0);
          if (c.scan_line < VisibleLines) shown++;
          put_cell(c);
        end
      end
      no_gaps = 1'b0;
    end

    // Wait out the last words, then give the verdict
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_cell_attribute_decoder_tb: done, clean");
    end else begin
      $display("text_cell_attribute_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
